### hdl/mvs_pkg.sv
package mvs_pkg;

    // Fixed field widths of the transaction ports
    localparam int FLOW_KEY_W = 64;
    localparam int IN_IDX_W   = 12;
    localparam int COUNT_W    = 32;
    localparam int ROWS       = 2;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef enum logic {
        CMD_UPDATE = 1'b0,
        CMD_QUERY  = 1'b1
    } t_cmd;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

### hdl/mvs_front.sv
module mvs_front #(
    parameter int BUCKETS_PER_ROW = 4096,
    parameter int KEY_BITS        = 64,
    localparam int IDX_W          = $clog2(BUCKETS_PER_ROW),
    localparam int DW             = 1 + KEY_BITS + 2 * IDX_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_command,
    input  logic [mvs_pkg::FLOW_KEY_W-1:0] i_flow_key,
    input  logic [mvs_pkg::IN_IDX_W-1:0]  i_row0_index,
    input  logic [mvs_pkg::IN_IDX_W-1:0]  i_row1_index,
    input  logic                          i_hold,
    input  mvs_pkg::t_q_status            i_q_status,
    output logic                          o_push,
    output logic [DW-1:0]                 o_data
);

    // Index reduction by reciprocal: quotient estimate is exact or one short
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP       = (1 << RECIP_SHIFT) / BUCKETS_PER_ROW;
    localparam int PROD_W      = mvs_pkg::IN_IDX_W + RECIP_SHIFT;
    localparam int QB_W        = mvs_pkg::IN_IDX_W + 17;

    logic                         r_vld;
    mvs_pkg::t_cmd                r_cmd;
    logic [KEY_BITS-1:0]          r_key;
    logic [mvs_pkg::IN_IDX_W-1:0] r_idx0;
    logic [mvs_pkg::IN_IDX_W-1:0] r_idx1;
    logic [mvs_pkg::IN_IDX_W-1:0] r_q0;
    logic [mvs_pkg::IN_IDX_W-1:0] r_q1;

    logic              accept;
    logic [PROD_W-1:0] prod0;
    logic [PROD_W-1:0] prod1;
    logic [IDX_W-1:0]  rem0;
    logic [IDX_W-1:0]  rem1;

    function automatic logic [IDX_W-1:0] rem_of(input logic [mvs_pkg::IN_IDX_W-1:0] idx,
                                               input logic [mvs_pkg::IN_IDX_W-1:0] q);
        logic [QB_W-1:0] qb;
        logic [QB_W-1:0] diff;
        qb   = QB_W'(q) * QB_W'(BUCKETS_PER_ROW);
        diff = QB_W'(idx) - qb;
        if (diff >= QB_W'(BUCKETS_PER_ROW)) begin
            diff = diff - QB_W'(BUCKETS_PER_ROW);
        end
        return diff[IDX_W-1:0];
    endfunction

    // Handshake: stage frees when its item moves into the queue
    assign o_push = r_vld && !i_q_status.full;
    assign o_busy = i_hold || (r_vld && i_q_status.full);
    assign accept = i_start && !o_busy;

    assign prod0 = PROD_W'(i_row0_index) * PROD_W'(RECIP);
    assign prod1 = PROD_W'(i_row1_index) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    // Transaction capture with quotient estimates
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= mvs_pkg::t_cmd'(i_command);
            r_key  <= i_flow_key[KEY_BITS-1:0];
            r_idx0 <= i_row0_index;
            r_idx1 <= i_row1_index;
            r_q0   <= prod0[PROD_W-1 -: mvs_pkg::IN_IDX_W];
            r_q1   <= prod1[PROD_W-1 -: mvs_pkg::IN_IDX_W];
        end
    end

    // Remainder with one correction step
    assign rem0   = rem_of(r_idx0, r_q0);
    assign rem1   = rem_of(r_idx1, r_q1);
    assign o_data = {r_cmd, r_key, rem0, rem1};

endmodule

### hdl/mvs_queue.sv
module mvs_queue #(
    parameter int DW = 89
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [DW-1:0]      i_data,
    input  logic               i_pop,
    output logic [DW-1:0]      o_data,
    output mvs_pkg::t_q_status o_status
);

    localparam int PW = mvs_pkg::QUEUE_PTR_W;

    logic [DW-1:0] r_data [mvs_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count;

    logic push_ok;
    logic pop_ok;

    assign o_status.full  = (r_count == (PW + 1)'(mvs_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign push_ok        = i_push && !o_status.full;
    assign pop_ok         = i_pop && !o_status.empty;
    assign o_data         = r_data[r_rd_ptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

endmodule

### hdl/mvs_back.sv
module mvs_back #(
    parameter int BUCKETS_PER_ROW = 4096,
    parameter int KEY_BITS        = 64,
    localparam int IDX_W          = $clog2(BUCKETS_PER_ROW),
    localparam int DW             = 1 + KEY_BITS + 2 * IDX_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mvs_pkg::t_q_status         i_q_status,
    input  logic [DW-1:0]              i_q_data,
    output logic                       o_pop,
    output logic                       o_clearing,
    output logic                       o_valid,
    output logic [mvs_pkg::COUNT_W-1:0] o_estimate
);

    localparam int CW     = mvs_pkg::COUNT_W;
    localparam int WORD_W = KEY_BITS + 2 * CW;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    // Bucket store, one array per row: {key, total, vote}
    logic [WORD_W-1:0] r_mem0 [BUCKETS_PER_ROW];
    logic [WORD_W-1:0] r_mem1 [BUCKETS_PER_ROW];
    logic [WORD_W-1:0] r_rd0;
    logic [WORD_W-1:0] r_rd1;

    t_state              r_state;
    t_state              n_state;
    logic [IDX_W-1:0]    r_clr_addr;
    logic [IDX_W-1:0]    n_clr_addr;
    logic                r_valid;
    logic                n_valid;
    logic [CW-1:0]       r_estimate;
    mvs_pkg::t_cmd       r_cmd;
    logic [KEY_BITS-1:0] r_key;
    logic [IDX_W-1:0]    r_idx0;
    logic [IDX_W-1:0]    r_idx1;

    logic [IDX_W-1:0]  head_idx0;
    logic [IDX_W-1:0]  head_idx1;
    logic              we;
    logic [IDX_W-1:0]  waddr0;
    logic [IDX_W-1:0]  waddr1;
    logic [WORD_W-1:0] wdata0;
    logic [WORD_W-1:0] wdata1;
    logic [CW-1:0]     bound0;
    logic [CW-1:0]     bound1;
    logic [CW-1:0]     best;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (v == '1) ? v : v + CW'(1);
    endfunction

    // Majority vote on one bucket
    function automatic logic [WORD_W-1:0] vote_word(input logic [WORD_W-1:0] w,
                                                    input logic [KEY_BITS-1:0] k);
        logic [KEY_BITS-1:0] ck;
        logic [CW-1:0]       t;
        logic [CW-1:0]       v;
        ck = w[WORD_W-1 -: KEY_BITS];
        t  = w[2*CW-1 -: CW];
        v  = w[CW-1:0];
        t  = sat_inc(t);
        if (ck == '0) begin
            ck = k;
            v  = CW'(1);
        end else if (ck == k) begin
            v = sat_inc(v);
        end else if (v > CW'(1)) begin
            v = v - CW'(1);
        end else begin
            ck = k;
            v  = '0;
        end
        return {ck, t, v};
    endfunction

    // Count bound of one bucket for the key
    function automatic logic [CW-1:0] bound_of(input logic [WORD_W-1:0] w,
                                               input logic [KEY_BITS-1:0] k);
        logic [CW-1:0] t;
        logic [CW-1:0] v;
        logic [CW:0]   sum;
        logic [CW-1:0] diff;
        logic [CW-1:0] b;
        t    = w[2*CW-1 -: CW];
        v    = w[CW-1:0];
        sum  = {1'b0, t} + {1'b0, v};
        diff = t - v;
        if (w[WORD_W-1 -: KEY_BITS] == k) begin
            b = sum[CW:1];
        end else if (v > t) begin
            b = '0;
        end else begin
            b = {1'b0, diff[CW-1:1]};
        end
        return b;
    endfunction

    assign head_idx0 = i_q_data[2*IDX_W-1 -: IDX_W];
    assign head_idx1 = i_q_data[IDX_W-1:0];

    assign o_pop      = (r_state == S_IDLE) && !i_q_status.empty;
    assign o_clearing = (r_state == S_CLEAR);
    assign o_valid    = r_valid;
    assign o_estimate = r_estimate;

    // Write port: clearing sweep or update write-back
    always_comb begin
        bound0 = bound_of(r_rd0, r_key);
        bound1 = bound_of(r_rd1, r_key);
        best   = (bound1 < bound0) ? bound1 : bound0;
        if (r_state == S_CLEAR) begin
            we     = 1'b1;
            waddr0 = r_clr_addr;
            waddr1 = r_clr_addr;
            wdata0 = '0;
            wdata1 = '0;
        end else begin
            we     = (r_state == S_EXEC) && (r_cmd == mvs_pkg::CMD_UPDATE);
            waddr0 = r_idx0;
            waddr1 = r_idx1;
            wdata0 = vote_word(r_rd0, r_key);
            wdata1 = vote_word(r_rd1, r_key);
        end
    end

    // Next state
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_valid    = 1'b0;
        case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == IDX_W'(BUCKETS_PER_ROW - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_valid = (r_cmd == mvs_pkg::CMD_QUERY);
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, registered outputs and the transaction in work
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_valid    <= n_valid;
            if (r_state == S_EXEC) begin
                r_estimate <= best;
            end
            if (o_pop) begin
                r_cmd  <= mvs_pkg::t_cmd'(i_q_data[DW-1]);
                r_key  <= i_q_data[DW-2 -: KEY_BITS];
                r_idx0 <= head_idx0;
                r_idx1 <= head_idx1;
            end
        end
    end

    // Bucket memories: read at the queue head, written back in the following cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem0[waddr0] <= wdata0;
            r_mem1[waddr1] <= wdata1;
        end
        r_rd0 <= r_mem0[head_idx0];
        r_rd1 <= r_mem1[head_idx1];
    end

endmodule

### hdl/majority_vote_heavy_flow_sketch.sv
// Channel   Direction  Handshake              Ports
// command   in         start high, busy low   i_command i_flow_key i_row0_index i_row1_index
// result    out        o_valid strobe         o_estimate
//
// The back end handles one transaction at a time: its idle state pops it and reads both
// bucket memories, then its exec state votes or bounds and writes back.
// A query result passes the front register, the queue, both back states and o_valid; updates give none.
// After reset the store is swept to zero with busy high.
// busy also rises while the front stage waits on a full command queue.
// Results cannot be stalled by the receiver.
module majority_vote_heavy_flow_sketch #(
    parameter int BUCKETS_PER_ROW = 4096,
    parameter int KEY_BITS        = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_command,
    input  logic [mvs_pkg::FLOW_KEY_W-1:0] i_flow_key,
    input  logic [mvs_pkg::IN_IDX_W-1:0]   i_row0_index,
    input  logic [mvs_pkg::IN_IDX_W-1:0]   i_row1_index,
    output logic                           o_valid,
    output logic [mvs_pkg::COUNT_W-1:0]    o_estimate
);

    localparam int IDX_W = $clog2(BUCKETS_PER_ROW);
    localparam int DW    = 1 + KEY_BITS + 2 * IDX_W;

    logic               push;
    logic [DW-1:0]      push_data;
    logic               pop;
    logic [DW-1:0]      head_data;
    logic               clearing;
    mvs_pkg::t_q_status q_status;

    // Accept and reduce indices
    mvs_front #(
        .BUCKETS_PER_ROW(BUCKETS_PER_ROW),
        .KEY_BITS       (KEY_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_command   (i_command),
        .i_flow_key  (i_flow_key),
        .i_row0_index(i_row0_index),
        .i_row1_index(i_row1_index),
        .i_hold      (clearing),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_data      (push_data)
    );

    // Command queue
    mvs_queue #(
        .DW(DW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (head_data),
        .o_status(q_status)
    );

    // Bucket store and vote engine
    mvs_back #(
        .BUCKETS_PER_ROW(BUCKETS_PER_ROW),
        .KEY_BITS       (KEY_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_status(q_status),
        .i_q_data  (head_data),
        .o_pop     (pop),
        .o_clearing(clearing),
        .o_valid   (o_valid),
        .o_estimate(o_estimate)
    );

endmodule
